/* rtl/pwm_prescaler_period_solver_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef PWM_PRESCALER_PERIOD_SOLVER_CORE_DEFINES_SVH
`define PWM_PRESCALER_PERIOD_SOLVER_CORE_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define PPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/pps_pkg.sv */
package pps_pkg;

  localparam int PERIOD_BITS   = 16;
  localparam int PRESCALE_BITS = 16;
  localparam int DATA_BITS     = 32;
  localparam int PRE_W         = PRESCALE_BITS + 1;

  // Clock edges from the accepting edge to the edge that takes the result word:
  // two divider pipelines, the prescaler stage and the output register.
  localparam int RESULT_LATENCY = 2 * DATA_BITS + 2;

  localparam logic [DATA_BITS-1:0] CLOCK_RESET = 32'd16000000;
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};
  localparam logic [PRE_W-1:0] PRESCALE_MAX = PRE_W'(1) << PRESCALE_BITS;

  // Side data that travels with a request through the solver.
  typedef struct packed {
    logic                 err;
    logic                 valid;
    logic [DATA_BITS-1:0] duty;
    logic [PRE_W-1:0]     pre;
  } req_ctl_t;

endpackage

/* rtl/pwm_prescaler_period_solver_core.sv */
// Channel  | Handshake          | Payload
// request  | start / busy       | in_channel_number, in_duty_request, in_frequency_hz
// result   | out_strobe         | out_prescale_value .. out_range_error
// config   | cfg_we             | cfg_data (clock in hertz)
// Every request is taken at its edge, and its result word passes through
// 32 divider stages for clock/frequency, one prescaler stage, 32 divider stages
// for quotient/prescaler and one output register. Range errors take the same path.
// busy is held low, so a new word can be taken in every cycle; the receiver cannot stall.
// Reset is synchronous, active low, clears the valid bits and loads the clock with 16 MHz.
module pwm_prescaler_period_solver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_channel_number,
  input  logic [31:0] in_duty_request,
  input  logic [31:0] in_frequency_hz,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        out_strobe,
  output logic [16:0] out_prescale_value,
  output logic [15:0] out_period_value,
  output logic [15:0] out_compare_value,
  output logic        out_channel_valid,
  output logic        out_range_error
);

  logic [31:0]       clock_r;
  pps_pkg::req_ctl_t ctl;
  logic              accept;

  always_ff @(posedge clk) begin
    if (!rst_n) clock_r <= pps_pkg::CLOCK_RESET;
    else if (cfg_we) clock_r <= cfg_data;
  end

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign ctl.err   = (in_frequency_hz == 32'd0) || (in_frequency_hz > clock_r);
  assign ctl.valid = (in_channel_number >= 8'd1) && (in_channel_number <= 8'd4);
  assign ctl.duty  = in_duty_request;
  assign ctl.pre   = '0;

  pps_solver u_solver (
    .clk(clk), .rst_n(rst_n), .start(accept), .clock_hz(clock_r),
    .freq(in_frequency_hz), .ctl_in(ctl), .res_vld(out_strobe),
    .res_pre(out_prescale_value), .res_per(out_period_value),
    .res_cmp(out_compare_value), .res_chan_ok(out_channel_valid),
    .res_err(out_range_error)
  );

endmodule

/* rtl/pps_divider.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module pps_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [pps_pkg::DATA_BITS-1:0] dividend,
  input  logic [pps_pkg::DATA_BITS-1:0] divisor,
  input  pps_pkg::req_ctl_t             in_ctl,
  output logic                          out_vld,
  output logic [pps_pkg::DATA_BITS-1:0] quotient,
  output pps_pkg::req_ctl_t             out_ctl
);

  localparam int W = pps_pkg::DATA_BITS;

  for (genvar g = 0; g < W; g++) begin : g_stage
    logic              vld_in;
    logic [W-1:0]      rem_in;
    logic [W-1:0]      quo_in;
    logic [W-1:0]      dsr_in;
    pps_pkg::req_ctl_t ctl_in;
    logic [W:0]        shf;
    logic [W:0]        dif;
    logic [W-1:0]      rem_nxt;
    logic [W-1:0]      quo_nxt;
    logic              vld_r;
    logic [W-1:0]      rem_r;
    logic [W-1:0]      quo_r;
    logic [W-1:0]      dsr_r;
    pps_pkg::req_ctl_t ctl_r;

    if (g == 0) begin : g_head
      assign vld_in = in_vld;
      assign rem_in = '0;
      assign quo_in = dividend;
      assign dsr_in = divisor;
      assign ctl_in = in_ctl;
    end else begin : g_body
      assign vld_in = g_stage[g-1].vld_r;
      assign rem_in = g_stage[g-1].rem_r;
      assign quo_in = g_stage[g-1].quo_r;
      assign dsr_in = g_stage[g-1].dsr_r;
      assign ctl_in = g_stage[g-1].ctl_r;
    end

    // The remainder stays below the divisor, so it always fits in W bits.
    assign shf = {rem_in, quo_in[W-1]};
    assign dif = shf - {1'b0, dsr_in};

    always_comb begin
      if (shf >= {1'b0, dsr_in}) begin
        rem_nxt = dif[W-1:0];
        quo_nxt = {quo_in[W-2:0], 1'b1};
      end else begin
        rem_nxt = shf[W-1:0];
        quo_nxt = {quo_in[W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_in;
      end
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dsr_r <= dsr_in;
      ctl_r <= ctl_in;
    end
  end

  assign out_vld  = g_stage[W-1].vld_r;
  assign quotient = g_stage[W-1].quo_r;
  assign out_ctl  = g_stage[W-1].ctl_r;

endmodule

/* rtl/pps_solver.sv */
// Pipeline: q = clk/freq, p = q/(2^N+1)+1 in closed form, period = q/p - 1.
module pps_solver (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [pps_pkg::DATA_BITS-1:0]   clock_hz,
  input  logic [pps_pkg::DATA_BITS-1:0]   freq,
  input  pps_pkg::req_ctl_t               ctl_in,
  output logic                            res_vld,
  output logic [pps_pkg::PRE_W-1:0]       res_pre,
  output logic [pps_pkg::PERIOD_BITS-1:0] res_per,
  output logic [pps_pkg::PERIOD_BITS-1:0] res_cmp,
  output logic                            res_chan_ok,
  output logic                            res_err
);

  localparam int W  = pps_pkg::DATA_BITS;
  localparam int PB = pps_pkg::PERIOD_BITS;
  localparam int PW = pps_pkg::PRE_W;

  logic              q_vld;
  logic [W-1:0]      q_quo;
  pps_pkg::req_ctl_t q_ctl;
  logic [W-PB-1:0]   est;
  logic [W:0]        est_prod;
  logic [W:0]        pre_full;
  pps_pkg::req_ctl_t pre_ctl_nxt;
  logic              pre_vld_r;
  logic [W-1:0]      pre_q_r;
  pps_pkg::req_ctl_t pre_ctl_r;
  logic              p_vld;
  logic [W-1:0]      p_quo;
  pps_pkg::req_ctl_t p_ctl;
  logic [W-1:0]      per_m1;
  logic [PW-1:0]     res_pre_nxt;
  logic [PB-1:0]     res_per_nxt;
  logic [PB-1:0]     res_cmp_nxt;
  logic              res_vld_r;
  logic [PW-1:0]     res_pre_r;
  logic [PB-1:0]     res_per_r;
  logic [PB-1:0]     res_cmp_r;
  logic              res_chan_ok_r;
  logic              res_err_r;

  pps_divider u_div_q (
    .clk(clk), .rst_n(rst_n), .in_vld(start), .dividend(clock_hz),
    .divisor(freq), .in_ctl(ctl_in), .out_vld(q_vld), .quotient(q_quo),
    .out_ctl(q_ctl)
  );

  // With q below 2^(2N), q/(2^N+1) is either q >> N or one less than that.
  always_comb begin
    est      = q_quo[W-1:PB];
    est_prod = {1'b0, est, {PB{1'b0}}} + (W+1)'(est);
    if (est_prod > {1'b0, q_quo}) pre_full = (W+1)'(est);
    else pre_full = (W+1)'(est) + (W+1)'(1);
    pre_ctl_nxt = q_ctl;
    if (pre_full > (W+1)'(pps_pkg::PRESCALE_MAX)) pre_ctl_nxt.pre = pps_pkg::PRESCALE_MAX;
    else pre_ctl_nxt.pre = pre_full[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else begin
      pre_vld_r <= q_vld;
    end
    pre_q_r   <= q_quo;
    pre_ctl_r <= pre_ctl_nxt;
  end

  pps_divider u_div_per (
    .clk(clk), .rst_n(rst_n), .in_vld(pre_vld_r), .dividend(pre_q_r),
    .divisor(W'(pre_ctl_r.pre)), .in_ctl(pre_ctl_r), .out_vld(p_vld),
    .quotient(p_quo), .out_ctl(p_ctl)
  );

  always_comb begin
    per_m1      = p_quo - W'(1);
    res_pre_nxt = p_ctl.pre;
    res_per_nxt = pps_pkg::PERIOD_MAX;
    res_cmp_nxt = '0;
    if (p_ctl.err) begin
      res_pre_nxt = PW'(1);
    end else begin
      if (per_m1 <= W'(pps_pkg::PERIOD_MAX)) res_per_nxt = per_m1[PB-1:0];
      if (p_ctl.valid) begin
        if (p_ctl.duty > W'(res_per_nxt)) res_cmp_nxt = res_per_nxt;
        else res_cmp_nxt = p_ctl.duty[PB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= p_vld;
    end
    res_pre_r     <= res_pre_nxt;
    res_per_r     <= res_per_nxt;
    res_cmp_r     <= res_cmp_nxt;
    res_chan_ok_r <= p_ctl.valid;
    res_err_r     <= p_ctl.err;
  end

  assign res_vld     = res_vld_r;
  assign res_pre     = res_pre_r;
  assign res_per     = res_per_r;
  assign res_cmp     = res_cmp_r;
  assign res_chan_ok = res_chan_ok_r;
  assign res_err     = res_err_r;

endmodule

/* rtl/pps_checker.sv */
`include "pwm_prescaler_period_solver_core_defines.svh"

module pps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [16:0] out_prescale_value,
  input logic [15:0] out_compare_value,
  input logic [15:0] out_period_value,
  input logic        out_range_error
);

  `PPS_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy)
  `PPS_ASSERT_IMP(a_err_fields, clk, rst_n, out_strobe && out_range_error,
    out_prescale_value == 17'd1 && out_period_value == 16'hFFFF)
  `PPS_ASSERT_IMP(a_cmp_le_per, clk, rst_n, out_strobe,
    out_compare_value <= out_period_value)
  `PPS_ASSERT_IMP(a_latency, clk, rst_n, start && !busy,
    ##(pps_pkg::RESULT_LATENCY) out_strobe)

endmodule

bind pwm_prescaler_period_solver_core pps_checker u_pps_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_strobe(out_strobe),
  .out_prescale_value(out_prescale_value), .out_compare_value(out_compare_value),
  .out_period_value(out_period_value), .out_range_error(out_range_error)
);
